/* src/ipc_pkg.sv */
// Shared types, constants and color tables for the isometric point colormap.
package ipc_pkg;

	// Configuration register indexes
	localparam logic [3:0] REG_COS = 4'd0;
	localparam logic [3:0] REG_SIN = 4'd1;
	localparam logic [3:0] REG_MIN = 4'd2;
	localparam logic [3:0] REG_MAX = 4'd3;

	localparam logic signed [15:0] COS_RESET = 16'sd11585;
	localparam logic signed [15:0] SIN_RESET = 16'sd11585;

	// Queue depths
	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW    = $clog2(MQ_DEPTH);
	localparam int OQ_DEPTH = 32;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// Quotient bits of the ratio divider (Q0.16 plus one headroom bit)
	localparam int QBITS = 17;

	// Color segment codes
	localparam logic [2:0] SEG_NEG  = 3'd0;
	localparam logic [2:0] SEG_P0   = 3'd1;
	localparam logic [2:0] SEG_P1   = 3'd2;
	localparam logic [2:0] SEG_P2   = 3'd3;
	localparam logic [2:0] SEG_P3   = 3'd4;

	localparam logic [23:0] C_WHITE  = 24'hFFFFFF;
	localparam logic [23:0] C_NAVY   = 24'h000080;
	localparam logic [23:0] C_ROYAL  = 24'h4169E1;
	localparam logic [23:0] C_LGREEN = 24'h90EE90;
	localparam logic [23:0] C_FGREEN = 24'h228B22;
	localparam logic [23:0] C_CHOC   = 24'hD2691E;
	localparam logic [23:0] C_SADDLE = 24'h8B4513;

	// Word from the front part to the back part
	typedef struct packed {
		logic signed [26:0] px;    // (column-row)*cos_coef
		logic signed [27:0] py;    // (column+row)*sin_coef
		logic signed [15:0] h;
		logic [15:0]        amag;  // |h - min_level|
		logic [15:0]        smag;  // |max_level - min_level|
		logic               span0;
		logic               hneg;
		logic               hzero;
		logic               qneg;
	} fw_t;

	// Start color of a segment
	function automatic logic [23:0] seg_lo(input logic [2:0] seg);
		case (seg)
			SEG_NEG: seg_lo = C_NAVY;
			SEG_P0:  seg_lo = C_LGREEN;
			SEG_P1:  seg_lo = C_FGREEN;
			SEG_P2:  seg_lo = C_CHOC;
			SEG_P3:  seg_lo = C_SADDLE;
			default: seg_lo = C_WHITE;
		endcase
	endfunction

	// End color of a segment
	function automatic logic [23:0] seg_hi(input logic [2:0] seg);
		case (seg)
			SEG_NEG: seg_hi = C_ROYAL;
			SEG_P0:  seg_hi = C_FGREEN;
			SEG_P1:  seg_hi = C_CHOC;
			SEG_P2:  seg_hi = C_SADDLE;
			SEG_P3:  seg_hi = C_WHITE;
			default: seg_hi = C_WHITE;
		endcase
	endfunction

endpackage

/* src/isometric_point_colormap.sv */
// Top level: configuration registers and the front, queue and back parts.
//
//  channel  | handshake             | words
//  ---------+-----------------------+---------------------------------
//  point    | push / full           | column, row, point_height
//  result   | pop / empty           | screen_x, screen_y, rgb
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One point per cycle while full stays low; a point passes the front stages, the middle
// queue, the entry stage, the 17-stage restoring divider for the height ratio, the
// segment and blend stages and the result queue before its result shows on the ports.
// Reset is asynchronous; it empties all queues and loads the default coefficients.
// The back part holds up to 32 words in flight; when the result side stalls,
// the middle queue and then the front fill and full rises.
module isometric_point_colormap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [9:0]         column,
	input  logic [9:0]         row,
	input  logic signed [15:0] point_height,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] screen_x,
	output logic signed [20:0] screen_y,
	output logic [23:0]        rgb,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import ipc_pkg::*;

	logic signed [15:0] cos_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic               mq_push;
	logic               mq_full;
	logic               mq_pop;
	logic               mq_empty;
	fw_t                mq_din;
	fw_t                mq_dout;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RESET;
			sin_q <= SIN_RESET;
			min_q <= '0;
			max_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COS: cos_q <= cfg_data;
				REG_SIN: sin_q <= cfg_data;
				REG_MIN: min_q <= cfg_data;
				REG_MAX: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ipc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.column       (column),
		.row          (row),
		.point_height (point_height),
		.cos_coef     (cos_q),
		.sin_coef     (sin_q),
		.min_level    (min_q),
		.max_level    (max_q),
		.q_push       (mq_push),
		.q_word       (mq_din),
		.q_full       (mq_full)
	);

	ipc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.din    (mq_din),
		.full   (mq_full),
		.pop    (mq_pop),
		.dout   (mq_dout),
		.empty  (mq_empty)
	);

	ipc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (mq_empty),
		.q_word   (mq_dout),
		.q_pop    (mq_pop),
		.empty    (empty),
		.pop      (pop),
		.screen_x (screen_x),
		.screen_y (screen_y),
		.rgb      (rgb)
	);

endmodule

/* src/ipc_queue.sv */
// Short queue of front words between the front and back parts.
module ipc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ipc_pkg::fw_t  din,
	output logic          full,
	input  logic          pop,
	output ipc_pkg::fw_t  dout,
	output logic          empty
);
	import ipc_pkg::*;

	fw_t              mem_q [MQ_DEPTH];
	logic [MQ_AW-1:0] wr_q;
	logic [MQ_AW-1:0] rd_q;
	logic [MQ_AW:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (MQ_AW+1)'(MQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// Store pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/ipc_front.sv */
// Front part: accepts points, forms projection products and classifies the height.
module ipc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [9:0]         column,
	input  logic [9:0]         row,
	input  logic signed [15:0] point_height,
	input  logic signed [15:0] cos_coef,
	input  logic signed [15:0] sin_coef,
	input  logic signed [15:0] min_level,
	input  logic signed [15:0] max_level,
	output logic               q_push,
	output ipc_pkg::fw_t       q_word,
	input  logic               q_full
);
	import ipc_pkg::*;

	logic               v_s1;
	logic [9:0]         col_s1;
	logic [9:0]         row_s1;
	logic signed [15:0] h_s1;
	logic               v_s2;
	fw_t                w_s2;
	logic               rdy_s2;
	logic               rdy_s1;
	logic signed [10:0] dif;
	logic signed [11:0] sum;
	logic signed [16:0] a;
	logic signed [16:0] span;
	logic [16:0]        aabs;
	logic [16:0]        sabs;
	fw_t                w_d;

	assign rdy_s2 = !v_s2 || !q_full;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign full   = !rdy_s1;
	assign q_push = v_s2;
	assign q_word = w_s2;

	// Products and classification
	always_comb begin
		dif  = $signed({1'b0, col_s1}) - $signed({1'b0, row_s1});
		sum  = $signed({2'b00, col_s1}) + $signed({2'b00, row_s1});
		a    = 17'(h_s1) - 17'(min_level);
		span = 17'(max_level) - 17'(min_level);
		aabs = a[16] ? 17'(-a) : 17'(a);
		sabs = span[16] ? 17'(-span) : 17'(span);
		w_d.px    = 27'(dif * cos_coef);
		w_d.py    = 28'(sum * sin_coef);
		w_d.h     = h_s1;
		w_d.amag  = aabs[15:0];
		w_d.smag  = sabs[15:0];
		w_d.span0 = (span == '0);
		w_d.hneg  = h_s1[15];
		w_d.hzero = (h_s1 == '0);
		w_d.qneg  = a[16] ^ span[16];
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			col_s1 <= column;
			row_s1 <= row;
			h_s1   <= point_height;
		end
		if (rdy_s2) begin
			w_s2 <= w_d;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= push;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

endmodule

/* src/ipc_back.sv */
// Back part: ratio divider, color blend and result queue.
module ipc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  ipc_pkg::fw_t       q_word,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] screen_x,
	output logic signed [20:0] screen_y,
	output logic [23:0]        rgb
);
	import ipc_pkg::*;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [20:0] y;
		logic               white;
		logic               hneg;
		logic               qneg;
		logic               sat;
	} inf_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [20:0] y;
		logic [23:0]        rgb;
	} res_t;

	// Credit and queue control
	logic [OQ_AW:0]   credit_q;
	logic             pop_ok;
	logic             issue;
	res_t             oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] owr_q;
	logic [OQ_AW-1:0] ord_q;
	logic [OQ_AW:0]   ocnt_q;

	// Entry stage
	logic               v_s1;
	inf_t               inf_s1;
	logic [31:0]        r_s1;
	logic [15:0]        d_s1;
	logic signed [30:0] ysum;
	logic signed [26:0] xadj;
	logic signed [30:0] yadj;
	inf_t               inf_d;

	// Divider stages
	logic        dv_v   [QBITS];
	inf_t        dv_inf [QBITS];
	logic [31:0] dv_r   [QBITS];
	logic [15:0] dv_d   [QBITS];
	logic [QBITS-1:0] dv_q [QBITS];

	// Segment stage
	logic               v_s3;
	inf_t               inf_s3;
	logic [2:0]         seg_s3;
	logic [16:0]        t_s3;
	logic [16:0]        qmag;
	logic signed [18:0] rr;
	logic signed [20:0] tl;
	logic [2:0]         seg_d;
	logic [16:0]        t_d;

	// Blend stage
	logic        v_s4;
	res_t        res_s4;
	logic [23:0] mix;

	assign pop_ok = pop && !empty;
	assign issue  = !q_empty && (credit_q < (OQ_AW+1)'(OQ_DEPTH));
	assign q_pop  = issue;

	// Track items issued but not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({issue, pop_ok})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Finish projection and set up the division
	always_comb begin
		xadj = q_word.px + (q_word.px[26] ? 27'sd1023 : 27'sd0);
		ysum = 31'(q_word.py) - (31'(q_word.h) <<< 14);
		yadj = ysum + (ysum[30] ? 31'sd1023 : 31'sd0);
		inf_d.x     = 16'(xadj >>> 10);
		inf_d.y     = 21'(yadj >>> 10);
		inf_d.white = q_word.span0 || q_word.hzero;
		inf_d.hneg  = q_word.hneg;
		inf_d.qneg  = q_word.qneg;
		inf_d.sat   = {1'b0, q_word.amag} >= {q_word.smag, 1'b0};
	end

	always_ff @(posedge clk) begin
		inf_s1 <= inf_d;
		r_s1   <= {q_word.amag, 16'b0};
		d_s1   <= q_word.smag;
	end

	// Restoring divider, one quotient bit per stage
	for (genvar j = 0; j < QBITS; j++) begin : g_div
		logic [31:0]      r_in;
		logic [15:0]      d_in;
		logic [QBITS-1:0] q_in;
		inf_t             i_in;
		logic [32:0]      trial;
		logic             ge;
		if (j == 0) begin : g_first
			assign r_in = r_s1;
			assign d_in = d_s1;
			assign q_in = '0;
			assign i_in = inf_s1;
		end else begin : g_next
			assign r_in = dv_r[j-1];
			assign d_in = dv_d[j-1];
			assign q_in = dv_q[j-1];
			assign i_in = dv_inf[j-1];
		end
		assign trial = {17'b0, d_in} << (QBITS-1-j);
		assign ge    = {1'b0, r_in} >= trial;
		always_ff @(posedge clk) begin
			dv_r[j]   <= ge ? (r_in - trial[31:0]) : r_in;
			dv_d[j]   <= d_in;
			dv_q[j]   <= {q_in[QBITS-2:0], ge};
			dv_inf[j] <= i_in;
		end
	end

	// Valid chain through the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < QBITS; k++) begin
				dv_v[k] <= 1'b0;
			end
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			dv_v[0] <= v_s1;
			for (int k = 1; k < QBITS; k++) begin
				dv_v[k] <= dv_v[k-1];
			end
			v_s3 <= dv_v[QBITS-1];
			v_s4 <= v_s3;
		end
	end

	// Pick segment and clamp the local ratio
	always_comb begin
		qmag = dv_inf[QBITS-1].sat ? '1 : dv_q[QBITS-1];
		rr   = dv_inf[QBITS-1].qneg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
		if (dv_inf[QBITS-1].hneg) begin
			seg_d = SEG_NEG;
			tl    = 21'(rr);
		end else if (rr < 19'sd16384) begin
			seg_d = SEG_P0;
			tl    = 21'(rr) <<< 2;
		end else if (rr < 19'sd32768) begin
			seg_d = SEG_P1;
			tl    = (21'(rr) - 21'sd16384) <<< 2;
		end else if (rr < 19'sd49152) begin
			seg_d = SEG_P2;
			tl    = (21'(rr) - 21'sd32768) <<< 2;
		end else begin
			seg_d = SEG_P3;
			tl    = (21'(rr) - 21'sd49152) <<< 2;
		end
		if (tl < 21'sd0) begin
			t_d = '0;
		end else if (tl > 21'sd65536) begin
			t_d = 17'd65536;
		end else begin
			t_d = tl[16:0];
		end
	end

	always_ff @(posedge clk) begin
		inf_s3 <= dv_inf[QBITS-1];
		seg_s3 <= seg_d;
		t_s3   <= t_d;
	end

	// Blend each channel
	always_comb begin
		logic [23:0]        c1;
		logic [23:0]        c2;
		logic signed [8:0]  dch;
		logic signed [26:0] tot;
		c1 = seg_lo(seg_s3);
		c2 = seg_hi(seg_s3);
		mix = '0;
		for (int s = 0; s < 3; s++) begin
			dch = $signed({1'b0, c2[8*s +: 8]}) - $signed({1'b0, c1[8*s +: 8]});
			tot = $signed({3'b000, c1[8*s +: 8], 16'b0}) + 27'(dch * $signed({1'b0, t_s3}));
			mix[8*s +: 8] = tot[23:16];
		end
	end

	always_ff @(posedge clk) begin
		res_s4.x   <= inf_s3.x;
		res_s4.y   <= inf_s3.y;
		res_s4.rgb <= inf_s3.white ? C_WHITE : mix;
	end

	// Result queue
	assign empty    = (ocnt_q == '0);
	assign screen_x = oq_q[ord_q].x;
	assign screen_y = oq_q[ord_q].y;
	assign rgb      = oq_q[ord_q].rgb;

	always_ff @(posedge clk) begin
		if (v_s4) begin
			oq_q[owr_q] <= res_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s4) begin
				owr_q <= owr_q + 1'b1;
			end
			if (pop_ok) begin
				ord_q <= ord_q + 1'b1;
			end
			case ({v_s4, pop_ok})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the isometric point colormap: driver, monitor and predictor.
`timescale 1ns / 1ps

module testbench;
	import ipc_pkg::*;

	// Written to check that a write to an unused index is ignored
	localparam logic [3:0] REG_SPARE = 4'd7;
	localparam int LIMIT = 600000;

	typedef struct {
		logic [9:0]         col;
		logic [9:0]         rw;
		logic signed [15:0] hgt;
	} point_t;

	typedef struct {
		logic signed [15:0] sx;
		logic signed [20:0] sy;
		logic [23:0]        color;
	} pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [9:0]         column = '0;
	logic [9:0]         row = '0;
	logic signed [15:0] point_height = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [15:0] screen_x;
	logic signed [20:0] screen_y;
	logic [23:0]        rgb;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [3:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	point_t points_q[$];
	pixel_t pixels_q[$];

	// Predictor copy of the registers
	logic signed [15:0] k_cos = COS_RESET;
	logic signed [15:0] k_sin = SIN_RESET;
	logic signed [15:0] k_min = '0;
	logic signed [15:0] k_max = '0;

	int  errors = 0;
	int  cycles = 0;
	bit  calm = 1'b0;   // no idling on either side
	int  hold = 0;      // receiver hold-off, in cycles
	int  send_gap = 0;
	int  take_gap = 0;

	isometric_point_colormap i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (calm || r < 12)
			return 0;
		if (r < 19)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Blend two colors by a Q1.16 weight, clamped to 0..1
	function automatic logic [23:0] mix(logic [23:0] c1, logic [23:0] c2, longint t);
		logic [23:0] out;
		longint a, b, tot;
		out = '0;
		if (t < 0)
			t = 0;
		if (t > 65536)
			t = 65536;
		for (int s = 0; s < 24; s += 8) begin
			a = (c1 >> s) & 8'hFF;
			b = (c2 >> s) & 8'hFF;
			tot = a * 65536 + (b - a) * t;
			out[s +: 8] = tot[23:16];
		end
		return out;
	endfunction

	function automatic pixel_t project(point_t p);
		pixel_t px;
		longint c, r, h, span, q, x, y;
		c = p.col;
		r = p.rw;
		h = p.hgt;
		x = ((c - r) * k_cos) / 1024;
		y = ((c + r) * k_sin - h * 16384) / 1024;
		px.sx = x[15:0];
		px.sy = y[20:0];
		span = longint'(k_max) - longint'(k_min);
		if (span == 0 || h == 0) begin
			px.color = C_WHITE;
		end else begin
			q = ((h - k_min) * 65536) / span;
			if (h < 0)
				px.color = mix(C_NAVY, C_ROYAL, q);
			else if (q < 16384)
				px.color = mix(C_LGREEN, C_FGREEN, q * 4);
			else if (q < 32768)
				px.color = mix(C_FGREEN, C_CHOC, (q - 16384) * 4);
			else if (q < 49152)
				px.color = mix(C_CHOC, C_SADDLE, (q - 32768) * 4);
			else
				px.color = mix(C_SADDLE, C_WHITE, (q - 49152) * 4);
		end
		return px;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Drive points from the pending queue
	always @(posedge clk) begin
		point_t p;
		logic nxt;
		if (arst_n) begin
			nxt = push;
			if (push && !full) begin
				p.col = column;
				p.rw = row;
				p.hgt = point_height;
				pixels_q.push_back(project(p));
				nxt = 1'b0;
				send_gap = pick_gap();
			end
			if (!nxt) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (points_q.size() > 0) begin
					p = points_q.pop_front();
					column <= p.col;
					row <= p.rw;
					point_height <= p.hgt;
					nxt = 1'b1;
				end
			end
			push <= nxt;
		end
	end

	// Count down the receiver hold-off
	always @(posedge clk) begin
		if (hold > 0)
			hold <= hold - 1;
	end

	// Check each popped word against the oldest prediction
	always @(posedge clk) begin
		pixel_t w;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pixels_q.size() == 0) begin
					$display("unexpected word at cycle %0d", cycles);
					errors++;
				end else begin
					w = pixels_q.pop_front();
					if (screen_x !== w.sx)
						report("screen_x", screen_x, w.sx);
					if (screen_y !== w.sy)
						report("screen_y", screen_y, w.sy);
					if (rgb !== w.color)
						report("rgb", rgb, w.color);
				end
			end
			if (hold > 0) begin
				pop <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				pop <= 1'b0;
			end else begin
				take_gap = pick_gap();
				pop <= 1'b1;
			end
		end
	end

	// Track register writes in the predictor
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COS: k_cos <= cfg_data;
				REG_SIN: k_sin <= cfg_data;
				REG_MIN: k_min <= cfg_data;
				REG_MAX: k_max <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic wait_idle();
		while (points_q.size() > 0 || push || pixels_q.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic signed [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(logic signed [15:0] c, logic signed [15:0] s,
			logic signed [15:0] lo, logic signed [15:0] hi);
		wait_idle();
		write_reg(REG_COS, c);
		write_reg(REG_SIN, s);
		write_reg(REG_MIN, lo);
		write_reg(REG_MAX, hi);
	endtask

	task automatic add(int c, int r, int h);
		point_t p;
		p.col = 10'(c);
		p.rw = 10'(r);
		p.hgt = 16'(h);
		points_q.push_back(p);
	endtask

	// Mostly heights within the limits, some anywhere
	task automatic add_random(int n);
		int lo, hi;
		lo = (k_min < k_max) ? k_min : k_max;
		hi = (k_min < k_max) ? k_max : k_min;
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				add($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 65535) - 32768);
			else if ($urandom_range(0, 15) == 0)
				add($urandom_range(0, 1023), $urandom_range(0, 1023), 0);
			else
				add($urandom_range(0, 1023), $urandom_range(0, 1023),
					lo + int'($urandom_range(0, hi - lo)));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Equal limits at reset: everything white
		add(0, 0, 0);
		add(1023, 1023, 32767);
		add(1023, 0, -32768);
		add(0, 1023, 5);

		// Full-scale coefficients, symmetric limits: negative, white and the upper two segments
		setup(16'sd16384, 16'sd16384, -16'sd1000, 16'sd1000);
		write_reg(REG_SPARE, 16'h7FFF);
		add(1023, 0, -1000);
		add(0, 1023, 1000);
		add(1023, 1023, 0);
		add(5, 7, -1);
		add(5, 7, 1);
		add(3, 2, 400);
		add(3, 2, 600);
		add(3, 2, 900);
		add(9, 9, 32767);
		add(9, 9, -32768);

		// Negative extremes, widest limits
		setup(-16'sd16384, -16'sd16384, -16'sd32768, 16'sd32767);
		add(1023, 0, -32768);
		add(0, 1023, 32767);
		add(1023, 1023, 32767);
		add(0, 0, -32768);

		// Reversed limits
		setup(16'sd11585, -16'sd11585, 16'sd500, -16'sd500);
		add(10, 20, 250);
		add(10, 20, -250);
		add(10, 20, 2000);
		add_random(200);

		// Receiver holds off while points keep coming
		setup(16'sd11585, 16'sd6000, -16'sd2000, 16'sd8000);
		wait_idle();
		hold = 400;
		add_random(300);

		// No idling on either side
		setup(-16'sd7000, 16'sd16384, 16'sd0, 16'sd32767);
		wait_idle();
		calm = 1'b1;
		add_random(300);
		wait_idle();
		calm = 1'b0;

		// Random settings
		repeat (4) begin
			setup(16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
				16'($urandom_range(0, 65535) - 32768), 16'($urandom_range(0, 65535) - 32768));
			add_random(250);
		end

		wait_idle();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
src/ipc_pkg.sv
src/ipc_queue.sv
src/ipc_front.sv
src/ipc_back.sv
src/isometric_point_colormap.sv
test/testbench.sv
